### sv/msq_pkg.sv
// Package: shared types and codes for the multi-stream shared queue.
`default_nettype none
package msq_pkg;
    localparam logic [2:0] ACT_SEND        = 3'd0;
    localparam logic [2:0] ACT_RECV        = 3'd1;
    localparam logic [2:0] ACT_SEND_FINISH = 3'd2;
    localparam logic [2:0] ACT_RECV_FINISH = 3'd3;
    localparam logic [2:0] ACT_SET_CHOKE   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_EOF     = 3'd3;
    localparam logic [2:0] ST_AGAIN   = 3'd4;

    localparam logic [3:0] NO_STREAM = 4'hF;

    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic start;      // latch request fields (action, stream, payload, choke value)
        logic pop;        // pop head entry (read data valid next cycle)
        logic judge;      // evaluate popped head
        logic scan;       // evaluate flag scan for empty queue
        logic emit;       // load output register
    } msq_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic is_recv;
        logic choked;
        logic empty;
        logic head_dead;
    } msq_stat_t;
endpackage
`default_nettype wire

### sv/msq_if.sv
// Interfaces: request and result channels.
`default_nettype none
interface msq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [2:0]  stream;
    logic [31:0] payload;
    logic        choke_value;
    modport source (output valid, action, stream, payload, choke_value, input ready);
    modport sink   (input valid, action, stream, payload, choke_value, output ready);
endinterface

interface msq_rsp_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic signed [3:0] stream_out;
    logic [31:0]       payload_out;
    modport source (output valid, status, stream_out, payload_out, input ready);
    modport sink   (input valid, status, stream_out, payload_out, output ready);
endinterface
`default_nettype wire

### sv/msq_ctrl.sv
// Controller: sequences one request through the datapath.
`default_nettype none
module msq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire msq_pkg::msq_stat_t stat,
    output msq_pkg::msq_cmd_t      cmd
);
    import msq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_JUDGE = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // new request only when output slot free or being drained
    assign in_ready  = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_recv && !stat.choked)
                begin
                    if (stat.empty)
                        state_next = S_SCAN;
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    cmd.emit    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
                state_next = S_JUDGE;
            S_JUDGE:
            begin
                if (!stat.head_dead)
                begin
                    cmd.judge   = 1'b1;
                    cmd.emit    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.empty)
                    state_next = S_SCAN;
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_SCAN:
            begin
                cmd.scan    = 1'b1;
                cmd.emit    = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_IDLE && ovalid_reg)
        else $error("emit did not return to idle");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_read_judge: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_JUDGE)
        else $error("read not followed by judge");
endmodule
`default_nettype wire

### sv/msq_dp.sv
// Datapath: queue memory, pointers, per-stream counters and flags.
`default_nettype none
module msq_dp #(
    parameter int MAX_STREAMS   = 8,
    parameter int FIFO_DEPTH    = 64,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [3:0]         cfg_data,
    input  wire logic [2:0]         action,
    input  wire logic [2:0]         stream,
    input  wire logic [31:0]        payload,
    input  wire logic               choke_value,
    input  wire msq_pkg::msq_cmd_t  cmd,
    output msq_pkg::msq_stat_t      stat,
    output logic [2:0]              status,
    output logic signed [3:0]       stream_out,
    output logic [31:0]             payload_out
);
    import msq_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int PW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

    logic [SW-1:0]         mem_s [FIFO_DEPTH];
    logic [PW-1:0]         mem_p [FIFO_DEPTH];
    logic [SW-1:0]         head_s_reg;
    logic [PW-1:0]         head_p_reg;
    logic                  pop_d_reg;
    logic [AW-1:0]         rptr_reg, wptr_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         occ_reg [MAX_STREAMS];
    logic [MAX_STREAMS-1:0] sdone_reg, rdone_reg;
    logic                  choke_reg;
    logic [3:0]            limit_reg, total_reg;
    logic [2:0]            act_reg;
    logic [2:0]            strm_reg;
    logic [31:0]           pay_reg;
    logic                  chv_reg;
    logic [2:0]            res_st;
    logic [3:0]            res_s;
    logic [31:0]           res_p;
    logic [2:0]            st_reg;
    logic [3:0]            so_reg;
    logic [31:0]           po_reg;

    // clamped configuration
    logic [FW:0] eff_limit;
    logic [6:0]  eff_total;
    always_comb
    begin
        eff_limit = (limit_reg == 4'd0) ? (FW+1)'(1) : (FW+1)'(limit_reg);
        if (eff_limit > (FW+1)'(FIFO_DEPTH))
            eff_limit = (FW+1)'(FIFO_DEPTH);
        eff_total = (total_reg == 4'd0) ? 7'd1 : 7'(total_reg);
        if (eff_total > 7'(MAX_STREAMS))
            eff_total = 7'(MAX_STREAMS);
    end

    logic          s_ok;
    logic [SW-1:0] s_idx;
    assign s_ok  = 7'(strm_reg) < eff_total;
    assign s_idx = SW'(strm_reg);

    // scan of finish flags over streams in use (at most MAX_STREAMS flags)
    logic            scan_hit;
    logic [SW-1:0]   scan_idx;
    logic            all_done;
    always_comb
    begin
        scan_hit = 1'b0;
        scan_idx = '0;
        all_done = 1'b1;
        for (int i = MAX_STREAMS - 1; i >= 0; i--)
        begin
            if (7'(i) < eff_total)
            begin
                if (sdone_reg[i] && !rdone_reg[i])
                begin
                    scan_hit = 1'b1;
                    scan_idx = SW'(i);
                end
                if (!rdone_reg[i])
                    all_done = 1'b0;
            end
        end
    end

    assign stat.is_recv   = act_reg == ACT_RECV;
    assign stat.choked    = choke_reg;
    assign stat.empty     = fill_reg == '0;
    assign stat.head_dead = rdone_reg[head_s_reg];

    // memory
    logic do_push;
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_s[wptr_reg] <= s_idx;
            mem_p[wptr_reg] <= PW'(pay_reg);
        end
        if (cmd.pop)
        begin
            head_s_reg <= mem_s[rptr_reg];
            head_p_reg <= mem_p[rptr_reg];
        end
    end

    // result for non-receive actions and choked receives, decided in S_DEC
    logic [2:0] dec_st;
    logic       occ_full;
    assign occ_full = (FW+1)'(occ_reg[s_idx]) >= eff_limit
                      || fill_reg >= FW'(FIFO_DEPTH);
    always_comb
    begin
        do_push = 1'b0;
        dec_st  = ST_INVALID;
        unique case (act_reg)
            ACT_SEND:
                if (!s_ok || sdone_reg[s_idx]) dec_st = ST_INVALID;
                else if (rdone_reg[s_idx])     dec_st = ST_EOF;
                else if (occ_full)             dec_st = ST_FULL;
                else
                begin
                    dec_st  = ST_OK;
                    do_push = cmd.emit;
                end
            ACT_RECV:        dec_st = ST_AGAIN;
            ACT_SEND_FINISH: dec_st = s_ok ? ST_OK : ST_INVALID;
            ACT_RECV_FINISH: dec_st = s_ok ? ST_OK : ST_INVALID;
            ACT_SET_CHOKE:   dec_st = ST_OK;
            default:         dec_st = ST_INVALID;
        endcase
    end

    always_comb
    begin
        res_st = dec_st;
        res_s  = NO_STREAM;
        res_p  = '0;
        if (cmd.judge)
        begin
            res_st = ST_OK;
            res_s  = 4'(head_s_reg);
            res_p  = 32'(head_p_reg);
        end
        else if (cmd.scan)
        begin
            res_st = scan_hit ? ST_EOF : (all_done ? ST_EOF : ST_AGAIN);
            res_s  = scan_hit ? 4'(scan_idx) : NO_STREAM;
        end
    end

    logic fin_decide;
    assign fin_decide = cmd.emit && !cmd.judge && !cmd.scan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            fill_reg  <= '0;
            sdone_reg <= '0;
            rdone_reg <= '0;
            choke_reg <= 1'b0;
            limit_reg <= 4'd8;
            total_reg <= 4'd8;
            pop_d_reg <= 1'b0;
            for (int i = 0; i < MAX_STREAMS; i++)
                occ_reg[i] <= '0;
        end
        else
        begin
            pop_d_reg <= cmd.pop;
            if (cfg_we)
            begin
                if (cfg_index == REG_LIMIT) limit_reg <= cfg_data;
                else                        total_reg <= cfg_data;
            end
            if (do_push)
            begin
                wptr_reg <= (32'(wptr_reg) + 1 >= FIFO_DEPTH) ? '0 : wptr_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
                occ_reg[s_idx] <= occ_reg[s_idx] + 1'b1;
            end
            if (cmd.pop)
            begin
                rptr_reg <= (32'(rptr_reg) + 1 >= FIFO_DEPTH) ? '0 : rptr_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            // popped entry's stream is in the head register in the cycle after the pop
            if (pop_d_reg)
            begin
                if (occ_reg[head_s_reg] != '0)
                    occ_reg[head_s_reg] <= occ_reg[head_s_reg] - 1'b1;
            end
            if (fin_decide && s_ok)
            begin
                if (act_reg == ACT_SEND && !sdone_reg[s_idx] && rdone_reg[s_idx])
                    sdone_reg[s_idx] <= 1'b1;
                if (act_reg == ACT_SEND_FINISH)
                begin
                    sdone_reg[s_idx] <= 1'b1;
                    choke_reg        <= 1'b0;
                end
                if (act_reg == ACT_RECV_FINISH)
                    rdone_reg[s_idx] <= 1'b1;
            end
            if (fin_decide && act_reg == ACT_SET_CHOKE)
                choke_reg <= chv_reg;
            if (cmd.scan && scan_hit)
                rdone_reg[scan_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            act_reg  <= action;
            strm_reg <= stream;
            pay_reg  <= payload;
            chv_reg  <= choke_value;
        end
        if (cmd.emit)
        begin
            st_reg <= res_st;
            so_reg <= res_s;
            po_reg <= res_p;
        end
    end

    assign status      = st_reg;
    assign stream_out  = so_reg;
    assign payload_out = po_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(FIFO_DEPTH))
        else $error("fill level above depth");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> fill_reg != '0)
        else $error("pop from empty queue");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |-> fill_reg < FW'(FIFO_DEPTH))
        else $error("push into full queue");
endmodule
`default_nettype wire

### sv/multi_stream_shared_queue_top.sv
// Top level: multi-stream shared queue with per-stream occupancy limit.
// One request is handled at a time. Send, finish and choke requests are
// decoded in the cycle after acceptance, and the result register is
// loaded as the decode state ends. A receive that finds a live head
// entry goes through pop, memory read and check of the entry's stream
// before its result is loaded; each dropped entry of a receive-finished
// stream adds another memory read and check. A receive on an empty queue
// answers after a flag scan, also when the last dropped entry leaves the
// queue empty. A choked receive answers from the decode state like a
// send. A new request is taken only while the controller is idle and the
// result register is empty or being drained at that edge, so a stalled
// result holds off the input. No clearing pass is needed after reset.
`default_nettype none
module multi_stream_shared_queue_top #(
    parameter int MAX_STREAMS   = 8,
    parameter int FIFO_DEPTH    = 64,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data,
    msq_req_if.sink         req,
    msq_rsp_if.source       rsp
);
    import msq_pkg::*;

    msq_cmd_t  cmd;
    msq_stat_t stat;

    // controller: handshake and sequencing
    msq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: queue storage and per-stream state
    msq_dp #(
        .MAX_STREAMS   (MAX_STREAMS),
        .FIFO_DEPTH    (FIFO_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (req.action),
        .stream      (req.stream),
        .payload     (req.payload),
        .choke_value (req.choke_value),
        .cmd         (cmd),
        .stat        (stat),
        .status      (rsp.status),
        .stream_out  (rsp.stream_out),
        .payload_out (rsp.payload_out)
    );

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
        else $error("result changed while stalled");
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second request accepted while busy");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status <= ST_AGAIN)
        else $error("status code out of range");
endmodule
`default_nettype wire

### sim/multi_stream_shared_queue_top_tb.sv
// Testbench: drives directed and random queue requests and checks every result against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module multi_stream_shared_queue_top_tb;
    import msq_pkg::*;

    localparam int DEPTH = 64;
    localparam int NSTR  = 8;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  stream;
        logic [31:0] payload;
        logic        choke_value;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  stream_out;
        logic [31:0] payload_out;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [3:0] cfg_data = '0;

    msq_req_if req ();
    msq_rsp_if rsp ();

    multi_stream_shared_queue_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
    );

    always #4 clk = ~clk;

    // Predictor state: a mirror of the shared queue.
    logic [2:0]  q_stream [DEPTH];
    logic [31:0] q_payload [DEPTH];
    int          rd_ptr, wr_ptr, fill;
    int          occ [NSTR];
    bit          sent_fin [NSTR];
    bit          recv_fin [NSTR];
    bit          choked;
    logic [3:0]  lim_reg, tot_reg;

    request_t pending_reqs [$];
    result_t  expected_results [$];
    int  mismatches = 0;
    bit  quiet_tail = 0;       // no idling in the last part of the run
    int  drv_idle = 0, mon_idle = 0;
    bit  drive_hold = 0;       // sender holds off until all results are back

    function automatic int eff_limit();
        if (lim_reg < 1) return 1;
        return lim_reg;        // 4-bit register never exceeds queue depth
    endfunction

    function automatic int eff_total();
        if (tot_reg < 1) return 1;
        if (tot_reg > NSTR) return NSTR;
        return tot_reg;
    endfunction

    function automatic result_t predict_queue(request_t r);
        result_t o;
        int s, total, done;
        o.status = ST_INVALID;
        o.stream_out = NO_STREAM;
        o.payload_out = '0;
        s = r.stream;
        total = eff_total();
        case (r.action)
            ACT_SEND: begin
                if (s >= total || sent_fin[s]) o.status = ST_INVALID;
                else if (recv_fin[s])
                begin
                    sent_fin[s] = 1;
                    o.status = ST_EOF;
                end
                else if (occ[s] >= eff_limit() || fill >= DEPTH) o.status = ST_FULL;
                else
                begin
                    q_stream[wr_ptr] = 3'(s);
                    q_payload[wr_ptr] = r.payload;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    fill++;
                    occ[s]++;
                    o.status = ST_OK;
                end
            end
            ACT_RECV: begin
                if (choked) return '{ST_AGAIN, NO_STREAM, 32'd0};
                // pop, silently dropping entries of receive-finished streams
                while (fill > 0)
                begin
                    int hs;
                    logic [31:0] hp;
                    hs = q_stream[rd_ptr];
                    hp = q_payload[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                    if (occ[hs] > 0) occ[hs]--;
                    if (!recv_fin[hs]) return '{ST_OK, 4'(hs), hp};
                end
                // empty: one EOF per send-finished stream, then global EOF
                done = 0;
                for (int i = 0; i < total; i++)
                begin
                    if (!sent_fin[i] && !recv_fin[i]) continue;
                    if (!recv_fin[i])
                    begin
                        recv_fin[i] = 1;
                        return '{ST_EOF, 4'(i), 32'd0};
                    end
                    done++;
                end
                o.status = (done == total) ? ST_EOF : ST_AGAIN;
            end
            ACT_SEND_FINISH: begin
                if (s < total)
                begin
                    sent_fin[s] = 1;
                    choked = 0;
                    o.status = ST_OK;
                end
            end
            ACT_RECV_FINISH: begin
                if (s < total)
                begin
                    recv_fin[s] = 1;
                    o.status = ST_OK;
                end
            end
            ACT_SET_CHOKE: begin
                choked = r.choke_value;
                o.status = ST_OK;
            end
            default: o.status = ST_INVALID;
        endcase
        return o;
    endfunction

    // Driver: presents queued requests; predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.action <= '0;
            req.stream <= '0;
            req.payload <= '0;
            req.choke_value <= 1'b0;
            drv_idle <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_results.push_back(predict_queue({req.action, req.stream,
                                                          req.payload, req.choke_value}));
            if (!req.valid || req.ready)
            begin
                if (drv_idle > 0)
                begin
                    drv_idle <= drv_idle - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !drive_hold)
                begin
                    request_t n;
                    n = pending_reqs.pop_front();
                    {req.action, req.stream, req.payload, req.choke_value} <= n;
                    req.valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 15) == 0)
                        drv_idle <= $urandom_range(1, 17);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure; compares each result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            mon_idle <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d stream=%0d payload=%h",
                                 rsp.status, rsp.stream_out, rsp.payload_out);
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (e.status !== rsp.status || e.stream_out !== rsp.stream_out ||
                        e.payload_out !== rsp.payload_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d/%h/%h got %0d/%h/%h",
                                     e.status, e.stream_out, e.payload_out,
                                     rsp.status, rsp.stream_out, rsp.payload_out);
                    end
                end
            end
            if (mon_idle > 0)
            begin
                mon_idle <= mon_idle - 1;
                rsp.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 15) == 0)
            begin
                mon_idle <= $urandom_range(1, 17);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    function automatic request_t make_req(logic [2:0] a, logic [2:0] s,
                                          logic [31:0] p, logic c);
        request_t r;
        r.action = a;
        r.stream = s;
        r.payload = p;
        r.choke_value = c;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);   // let a receive in flight settle
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LIMIT) lim_reg = val;
        else tot_reg = val;
    endtask

    // Random phase: mostly sends and receives with occasional finishes/choke and invalid actions.
    task automatic load_random(int n);
        for (int i = 0; i < n; i++)
        begin
            int k;
            logic [2:0] a;
            k = $urandom_range(0, 99);
            if (k < 45) a = ACT_SEND;
            else if (k < 85) a = ACT_RECV;
            else if (k < 89) a = ACT_SEND_FINISH;
            else if (k < 92) a = ACT_RECV_FINISH;
            else if (k < 98) a = ACT_SET_CHOKE;
            else a = 3'($urandom_range(5, 7));
            pending_reqs.push_back(make_req(a, 3'($urandom), $urandom, 1'($urandom)));
        end
    endtask

    initial
    begin
        logic [3:0] lims [6];
        logic [3:0] tots [6];
        lims = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8};
        tots = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd8};
        rd_ptr = 0; wr_ptr = 0; fill = 0; choked = 0;
        lim_reg = 4'd8; tot_reg = 4'd8;
        for (int i = 0; i < NSTR; i++)
        begin
            occ[i] = 0; sent_fin[i] = 0; recv_fin[i] = 0;
        end
        rsp.ready = 1'b0;
        req.valid = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every action, limits, choke, EOF paths.
        pending_reqs.push_back(make_req(ACT_RECV, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_SEND, 0, 32'hFFFF_FFFF, 1));
        pending_reqs.push_back(make_req(ACT_SEND, 7, 32'h0, 0));
        for (int i = 0; i < 9; i++)
            pending_reqs.push_back(make_req(ACT_SEND, 3, 32'hA5A5_0000 + i, 0));
        pending_reqs.push_back(make_req(ACT_SET_CHOKE, 0, 0, 1));
        pending_reqs.push_back(make_req(ACT_RECV, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_SEND_FINISH, 5, 0, 0));
        pending_reqs.push_back(make_req(ACT_SEND, 5, 1, 0));
        pending_reqs.push_back(make_req(ACT_RECV_FINISH, 3, 0, 0));
        pending_reqs.push_back(make_req(ACT_SEND, 3, 2, 0));
        pending_reqs.push_back(make_req(ACT_RECV, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_RECV, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_RECV, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_RECV, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 0, 0, 0));
        wait_drained();

        // Random phases across register settings; phase 2 also holds off the sender.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_LIMIT, lims[ph]);
            write_reg(REG_TOTAL, tots[ph]);
            if (ph == 5) quiet_tail = 1;
            load_random(300);
            if (ph == 2)
            begin
                while (pending_reqs.size() > 150) @(posedge clk);
                drive_hold = 1;
                while (req.valid || expected_results.size() > 0) @(posedge clk);
                drive_hold = 0;
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("multi_stream_shared_queue_top_tb: PASS");
        else
            $display("multi_stream_shared_queue_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("multi_stream_shared_queue_top_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### multi_stream_shared_queue_top.f
sv/msq_pkg.sv
sv/msq_if.sv
sv/msq_ctrl.sv
sv/msq_dp.sv
sv/multi_stream_shared_queue_top.sv
sim/multi_stream_shared_queue_top_tb.sv
